// ===== src/sle_pkg.sv =====
// sle_pkg: shared constants and types for the sorted list engine
// no dependencies; used by every module of the block
package sle_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ACT_W        = 2;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 5;
  localparam int STAT_W       = 3;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// ===== src/sle_cell.sv =====
// sle_cell: one slot of the sorted list, shifts toward either neighbor
// depends on sle_pkg
module sle_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5,
  parameter int PW    = 5
) (
  input  logic                            clk,
  input  sle_pkg::cell_ctrl_t             ctrl,
  input  logic signed [sle_pkg::VAL_W-1:0] value,
  input  logic [CW-1:0]                   count,
  input  logic [PW-1:0]                   pos,
  input  logic signed [sle_pkg::VAL_W-1:0] left_data,
  input  logic                            left_lt,
  input  logic signed [sle_pkg::VAL_W-1:0] right_data,
  output logic signed [sle_pkg::VAL_W-1:0] data,
  output logic                            lt_occ,
  output logic                            match
);
  import sle_pkg::*;

  localparam logic [CW-1:0] IDX    = CW'(INDEX);
  localparam logic [PW-1:0] IDX_P1 = PW'(INDEX + 1);

  logic occ;
  logic rem_sel;

  assign occ     = IDX < count;
  assign lt_occ  = occ && (data < value);
  assign match   = occ && (data == value);
  assign rem_sel = IDX_P1 >= pos;

  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt_occ) begin
      data <= left_lt ? value : left_data;
    end else if (ctrl.rem && rem_sel) begin
      data <= right_data;
    end
  end

endmodule

// ===== src/sorted_list_engine.sv =====
// sorted_list_engine: top level, a row of sle_cell slots and the command control
// depends on sle_pkg and sle_cell
//
//   port group   dir  handshake             payload
//   command      in   start, busy           action, value, position
//   result       out  done (one-cycle strobe) status, found_position, entry_count
//
// a command is first latched, then the cells compare and shift
// busy is high in the shift cycle; done follows in the next cycle with the result
// a new command may be started while done is shown
// synchronous reset clears the list length and the control; slot contents stay
// the receiver cannot stall the result, so the block never waits on it
module sorted_list_engine #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sle_pkg::ACT_W-1:0]         action,
  input  logic signed [sle_pkg::VAL_W-1:0]  value,
  input  logic [sle_pkg::POS_W-1:0]         position,
  output logic                              busy,
  output logic                              done,
  output logic [sle_pkg::STAT_W-1:0]        status,
  output logic [sle_pkg::POS_W-1:0]         found_position,
  output logic [sle_pkg::POS_W-1:0]         entry_count
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [ACT_W-1:0]        op_act;
  logic signed [VAL_W-1:0] op_value;
  logic [POS_W-1:0]        op_pos;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;

  logic signed [VAL_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]     cell_lt;
  logic [CAPACITY-1:0]     cell_match;
  cell_ctrl_t              ctrl;

  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     cnt_ext;
  logic [PW-1:0]     cnt_next_ext;
  logic [PW-1:0]     found_idx;
  logic [STAT_W-1:0] status_next;

  assign pos_ext      = PW'(op_pos);
  assign cnt_ext      = PW'(count);
  assign cnt_next_ext = PW'(count_next);

  always_comb begin
    found_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        found_idx = PW'(i + 1);
      end
    end
  end

  always_comb begin
    ctrl        = '0;
    count_next  = count;
    status_next = ST_OK;
    unique case (op_act)
      ACT_INSERT: begin
        if (count == CAP_C) begin
          status_next = ST_FULL;
        end else begin
          ctrl.ins   = busy;
          count_next = count + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status_next = ST_BADPOS;
        end else begin
          ctrl.rem   = busy;
          count_next = count - 1'b1;
        end
      end
      ACT_SEARCH: begin
        status_next = (found_idx == '0) ? ST_NOTFOUND : ST_OK;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sle_cell #(
      .INDEX(g),
      .CW   (CW),
      .PW   (PW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .value     (op_value),
      .count     (count),
      .pos       (pos_ext),
      .left_data ((g == 0) ? op_value : cell_data[(g == 0) ? 0 : g - 1]),
      .left_lt   ((g == 0) ? 1'b1 : cell_lt[(g == 0) ? 0 : g - 1]),
      .right_data((g == CAPACITY - 1) ? cell_data[g] :
                  cell_data[(g == CAPACITY - 1) ? g : g + 1]),
      .data      (cell_data[g]),
      .lt_occ    (cell_lt[g]),
      .match     (cell_match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_act   <= action;
      op_value <= value;
      op_pos   <= position;
    end
    if (busy) begin
      status         <= status_next;
      found_position <= (op_act == ACT_SEARCH) ? found_idx[POS_W-1:0] : '0;
      entry_count    <= cnt_next_ext[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      busy <= start && !busy;
      done <= busy;
      if (busy) begin
        count <= count_next;
      end
    end
  end

endmodule

// ===== src/sle_checker.sv =====
// sle_checker: port-level checks on the sorted list engine
// depends on sle_pkg; bound to sorted_list_engine
module sle_checker #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [sle_pkg::STAT_W-1:0] status,
  input logic [sle_pkg::POS_W-1:0]  found_position,
  input logic [sle_pkg::POS_W-1:0]  entry_count
);
  import sle_pkg::*;

  localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

  // every accepted transaction gets exactly one result: start raises busy, and busy raises done
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("no result for accepted transaction");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without transaction");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> found_position == '0)
    else $error("found position on failed transaction");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entry_count == CAP_P))
    else $error("full status with wrong entry count");

endmodule

bind sorted_list_engine sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .found_position(found_position),
  .entry_count   (entry_count)
);
